// File: rtl/core/psd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

    localparam int COORD_W        = 16;
    localparam int DIAM_W         = 18;
    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_BITS_DEF = 16;

    localparam logic signed [COORD_W-1:0] BOX_MIN_INIT = 16'sh7FFF;
    localparam logic signed [COORD_W-1:0] BOX_MAX_INIT = 16'sh8000;

    // status of a multi-cycle unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/psd_vertex_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface psd_vertex_if;

    logic                               valid;
    logic                               ready;
    logic signed [psd_pkg::COORD_W-1:0] coord_x;
    logic signed [psd_pkg::COORD_W-1:0] coord_y;
    logic signed [psd_pkg::COORD_W-1:0] coord_z;
    logic                               last_vertex;

    modport source (
        output valid,
        input  ready,
        output coord_x,
        output coord_y,
        output coord_z,
        output last_vertex
    );

    modport sink (
        input  valid,
        output ready,
        input  coord_x,
        input  coord_y,
        input  coord_z,
        input  last_vertex
    );

endinterface

`default_nettype wire

// File: rtl/core/psd_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface psd_result_if;

    logic                               valid;
    logic                               ready;
    logic signed [psd_pkg::COORD_W-1:0] box_min_x;
    logic signed [psd_pkg::COORD_W-1:0] box_max_x;
    logic signed [psd_pkg::COORD_W-1:0] box_min_y;
    logic signed [psd_pkg::COORD_W-1:0] box_max_y;
    logic signed [psd_pkg::COORD_W-1:0] box_min_z;
    logic signed [psd_pkg::COORD_W-1:0] box_max_z;
    logic        [psd_pkg::DIAM_W-1:0]  diameter;
    logic                               truncated;

    modport source (
        output valid,
        input  ready,
        output box_min_x,
        output box_max_x,
        output box_min_y,
        output box_max_y,
        output box_min_z,
        output box_max_z,
        output diameter,
        output truncated
    );

    modport sink (
        input  valid,
        output ready,
        input  box_min_x,
        input  box_max_x,
        input  box_min_y,
        input  box_max_y,
        input  box_min_z,
        input  box_max_z,
        input  diameter,
        input  truncated
    );

endinterface

`default_nettype wire

// File: rtl/core/psd_dist.sv
`timescale 1ns / 1ps
`default_nettype none

module psd_dist #(
    parameter int EXT_BITS = psd_pkg::COORD_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_vld,
    input  wire logic [3*EXT_BITS-1:0]         pa,
    input  wire logic [3*EXT_BITS-1:0]         pb,
    output logic      [2*(EXT_BITS+1)+1:0]     sum,
    output psd_pkg::unit_stat_t                stat
);

    localparam int DW = EXT_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 2;

    logic signed [DW-1:0] diff_comb [3];
    logic signed [DW-1:0] diff_reg  [3];
    logic        [PW-1:0] sq_reg    [3];
    logic        [SW-1:0] sum_reg;
    logic                 v1_reg;
    logic                 v2_reg;
    logic                 v3_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff_comb[k] = signed'({pa[k*EXT_BITS + EXT_BITS - 1], pa[k*EXT_BITS +: EXT_BITS]})
                         - signed'({pb[k*EXT_BITS + EXT_BITS - 1], pb[k*EXT_BITS +: EXT_BITS]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff_reg[k] <= diff_comb[k];
            sq_reg[k]   <= unsigned'(PW'(diff_reg[k]) * PW'(diff_reg[k]));
        end
        sum_reg <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
    end

    assign sum       = sum_reg;
    assign stat.done = v3_reg;
    assign stat.busy = v1_reg | v2_reg | v3_reg;

endmodule

`default_nettype wire

// File: rtl/core/psd_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module psd_isqrt #(
    parameter int SQ_W = 2 * (psd_pkg::COORD_BITS_DEF + 1) + 2
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [SQ_W-1:0]     rad,
    output logic      [SQ_W/2-1:0]   root,
    output psd_pkg::unit_stat_t      stat
);

    localparam int RT_W  = SQ_W / 2;
    localparam int CNT_W = $clog2(RT_W + 1);

    logic [SQ_W-1:0]   rad_reg;
    logic [RT_W+1:0]   rem_reg;
    logic [RT_W-1:0]   root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;

    logic [RT_W+3:0]   shifted;
    logic [RT_W+3:0]   subtr;
    logic [RT_W+4:0]   trial;

    assign shifted = {rem_reg, rad_reg[SQ_W-1 -: 2]};
    assign subtr   = {2'b00, root_reg, 2'b01};
    assign trial   = {1'b0, shifted} - {1'b0, subtr};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(RT_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - CNT_W'(1);
                done_reg <= (cnt_reg == CNT_W'(1));
            end
        end
    end

    // one result bit per cycle, restoring digit recurrence
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rad_reg <= rad_reg << 2;
            if (!trial[RT_W+4])
            begin
                rem_reg  <= trial[RT_W+1:0];
                root_reg <= {root_reg[RT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted[RT_W+1:0];
                root_reg <= {root_reg[RT_W-2:0], 1'b0};
            end
        end
    end

    assign root      = root_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> stat.busy)
        else $error("isqrt not busy after start");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> !stat.busy)
        else $error("isqrt done while still iterating");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> $past(cnt_reg == CNT_W'(1)))
        else $error("isqrt done without final step");

endmodule

`default_nettype wire

// File: rtl/core/point_set_diameter_and_bbox.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounding box and brute-force diameter of a vertex set. Each vertex word extends the box and
// is checked against the point store for duplicates by reading every stored entry through the
// store's single read port. A word marked last then runs the pairwise pass off the same port,
// one pair per cycle within each outer point's row, then drains the distance pipeline and takes
// a bit-serial square root of the largest squared distance. Distinct vertices beyond MAX_POINTS
// still extend the box, are left out of the diameter and set truncated. The result sits in an
// output register, so the next polyhedron may start while it waits to be taken.
module point_set_diameter_and_bbox #(
    parameter int MAX_POINTS = psd_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    psd_vertex_if.sink    vertex,
    psd_result_if.source  result
);

    localparam int COORD_W  = psd_pkg::COORD_W;
    localparam int DIAM_W   = psd_pkg::DIAM_W;
    localparam int EXT_BITS = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam int ENT_W    = 3 * EXT_BITS;
    localparam int SQ_W     = 2 * (EXT_BITS + 1) + 2;
    localparam int RT_W     = SQ_W / 2;
    localparam int IDX_W    = $clog2(MAX_POINTS);
    localparam int CNT_W    = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_PI_RD,
        ST_PI_CAP,
        ST_PJ,
        ST_DRAIN,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_FINISH
    } state_t;

    state_t                      state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            idx_reg, idx_next;
    logic [CNT_W-1:0]            i_reg, i_next;
    logic                        rvld_reg, rvld_next;
    logic                        dup_reg, dup_next;
    logic                        last_reg, last_next;
    logic                        ovf_reg, ovf_next;
    logic [ENT_W-1:0]            p_reg, p_next;
    logic [ENT_W-1:0]            pi_reg, pi_next;
    logic [SQ_W-1:0]             best_reg, best_next;
    logic signed [COORD_W-1:0]   bmin_reg [3];
    logic signed [COORD_W-1:0]   bmin_next [3];
    logic signed [COORD_W-1:0]   bmax_reg [3];
    logic signed [COORD_W-1:0]   bmax_next [3];
    logic                        out_vld_reg;

    logic signed [COORD_W-1:0]   omin_reg [3];
    logic signed [COORD_W-1:0]   omax_reg [3];
    logic [DIAM_W-1:0]           odiam_reg;
    logic                        otrunc_reg;

    // point store
    logic [ENT_W-1:0]            mem [MAX_POINTS];
    logic [ENT_W-1:0]            rdata_reg;
    logic                        rd_en;
    logic [IDX_W-1:0]            raddr;
    logic                        wr_en;

    logic signed [EXT_BITS-1:0]  vx, vy, vz;
    logic signed [COORD_W-1:0]   pin [3];
    logic [CNT_W-1:0]            cnt_after;
    logic [CNT_W-1:0]            i_inc;
    logic                        sq_start;
    logic                        out_load;
    logic                        dist_vld;
    logic [SQ_W-1:0]             dist_sum;
    logic [RT_W-1:0]             sq_root;
    psd_pkg::unit_stat_t         dist_stat;
    psd_pkg::unit_stat_t         sq_stat;

    assign vx     = vertex.coord_x[EXT_BITS-1:0];
    assign vy     = vertex.coord_y[EXT_BITS-1:0];
    assign vz     = vertex.coord_z[EXT_BITS-1:0];
    assign pin[0] = COORD_W'(vx);
    assign pin[1] = COORD_W'(vy);
    assign pin[2] = COORD_W'(vz);
    assign i_inc  = i_reg + CNT_W'(1);

    assign vertex.ready = (state_reg == ST_IDLE);
    assign dist_vld     = rvld_reg && (state_reg != ST_SCAN);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= p_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    psd_dist #(
        .EXT_BITS (EXT_BITS)
    ) u_dist (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_vld (dist_vld),
        .pa     (pi_reg),
        .pb     (rdata_reg),
        .sum    (dist_sum),
        .stat   (dist_stat)
    );

    psd_isqrt #(
        .SQ_W (SQ_W)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .rad   (best_reg),
        .root  (sq_root),
        .stat  (sq_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        i_next     = i_reg;
        rvld_next  = 1'b0;
        dup_next   = dup_reg;
        last_next  = last_reg;
        ovf_next   = ovf_reg;
        p_next     = p_reg;
        pi_next    = pi_reg;
        best_next  = best_reg;
        for (int k = 0; k < 3; k++)
        begin
            bmin_next[k] = bmin_reg[k];
            bmax_next[k] = bmax_reg[k];
        end
        rd_en     = 1'b0;
        raddr     = '0;
        wr_en     = 1'b0;
        sq_start  = 1'b0;
        out_load  = 1'b0;
        cnt_after = count_reg;

        if (dist_stat.done && (dist_sum > best_reg))
        begin
            best_next = dist_sum;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (vertex.valid)
                begin
                    p_next    = {vx, vy, vz};
                    last_next = vertex.last_vertex;
                    dup_next  = 1'b0;
                    idx_next  = '0;
                    for (int k = 0; k < 3; k++)
                    begin
                        if (pin[k] < bmin_reg[k])
                        begin
                            bmin_next[k] = pin[k];
                        end
                        if (pin[k] > bmax_reg[k])
                        begin
                            bmax_next[k] = pin[k];
                        end
                    end
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (idx_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    raddr     = idx_reg[IDX_W-1:0];
                    idx_next  = idx_reg + CNT_W'(1);
                    rvld_next = 1'b1;
                end
                else if (!rvld_reg)
                begin
                    state_next = ST_COMMIT;
                end
                if (rvld_reg && (rdata_reg == p_reg))
                begin
                    dup_next = 1'b1;
                end
            end

            ST_COMMIT:
            begin
                if (!dup_reg)
                begin
                    if (count_reg < CNT_W'(MAX_POINTS))
                    begin
                        wr_en     = 1'b1;
                        cnt_after = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                count_next = cnt_after;
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    best_next = '0;
                    i_next    = '0;
                    if (cnt_after >= CNT_W'(2))
                    begin
                        state_next = ST_PI_RD;
                    end
                    else
                    begin
                        state_next = ST_ROOT_GO;
                    end
                end
            end

            ST_PI_RD:
            begin
                rd_en      = 1'b1;
                raddr      = i_reg[IDX_W-1:0];
                state_next = ST_PI_CAP;
            end

            ST_PI_CAP:
            begin
                pi_next    = rdata_reg;
                rd_en      = 1'b1;
                raddr      = i_inc[IDX_W-1:0];
                idx_next   = i_reg + CNT_W'(2);
                rvld_next  = 1'b1;
                state_next = ST_PJ;
            end

            ST_PJ:
            begin
                if (idx_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    raddr     = idx_reg[IDX_W-1:0];
                    idx_next  = idx_reg + CNT_W'(1);
                    rvld_next = 1'b1;
                end
                else if ((i_reg + CNT_W'(2)) < count_reg)
                begin
                    i_next     = i_inc;
                    state_next = ST_PI_RD;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                if (!rvld_reg && !dist_stat.busy)
                begin
                    state_next = ST_ROOT_GO;
                end
            end

            ST_ROOT_GO:
            begin
                sq_start   = 1'b1;
                state_next = ST_ROOT_WAIT;
            end

            ST_ROOT_WAIT:
            begin
                if (sq_stat.done)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_vld_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    count_next = '0;
                    ovf_next   = 1'b0;
                    best_next  = '0;
                    for (int k = 0; k < 3; k++)
                    begin
                        bmin_next[k] = psd_pkg::BOX_MIN_INIT;
                        bmax_next[k] = psd_pkg::BOX_MAX_INIT;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            i_reg       <= '0;
            rvld_reg    <= 1'b0;
            dup_reg     <= 1'b0;
            last_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            best_reg    <= '0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                bmin_reg[k] <= psd_pkg::BOX_MIN_INIT;
                bmax_reg[k] <= psd_pkg::BOX_MAX_INIT;
            end
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            i_reg     <= i_next;
            rvld_reg  <= rvld_next;
            dup_reg   <= dup_next;
            last_reg  <= last_next;
            ovf_reg   <= ovf_next;
            best_reg  <= best_next;
            for (int k = 0; k < 3; k++)
            begin
                bmin_reg[k] <= bmin_next[k];
                bmax_reg[k] <= bmax_next[k];
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg  <= p_next;
        pi_reg <= pi_next;
        if (out_load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                omin_reg[k] <= bmin_reg[k];
                omax_reg[k] <= bmax_reg[k];
            end
            odiam_reg  <= DIAM_W'(sq_root);
            otrunc_reg <= ovf_reg;
        end
    end

    assign result.valid     = out_vld_reg;
    assign result.box_min_x = omin_reg[0];
    assign result.box_max_x = omax_reg[0];
    assign result.box_min_y = omin_reg[1];
    assign result.box_max_y = omax_reg[1];
    assign result.box_min_z = omin_reg[2];
    assign result.box_max_z = omax_reg[2];
    assign result.diameter  = odiam_reg;
    assign result.truncated = otrunc_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count above capacity");

    a_root_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        sq_stat.done |-> (state_reg == ST_ROOT_WAIT))
        else $error("square root finished outside its wait state");

    a_dist_in_pair_pass: assert property (@(posedge clk) disable iff (!rst_n)
        dist_stat.done |-> (state_reg == ST_PJ || state_reg == ST_PI_RD ||
                            state_reg == ST_PI_CAP || state_reg == ST_DRAIN))
        else $error("distance word outside the pairwise pass");

    a_store_grows: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("store write without count increment");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (result.valid && count_reg == '0 && !ovf_reg))
        else $error("result loaded without clearing state");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_PTS = psd_pkg::MAX_POINTS_DEF;

    typedef logic signed [psd_pkg::COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   last_vertex;
    } vertex_word_t;

    typedef struct packed {
        coord_t                      min_x;
        coord_t                      max_x;
        coord_t                      min_y;
        coord_t                      max_y;
        coord_t                      min_z;
        coord_t                      max_z;
        logic [psd_pkg::DIAM_W-1:0]  diameter;
        logic                        truncated;
    } hull_result_t;

    logic clk = 1'b0;
    logic rst_n;

    psd_vertex_if vertex_bus ();
    psd_result_if result_bus ();

    point_set_diameter_and_bbox #(
        .MAX_POINTS (MAX_PTS),
        .COORD_BITS (psd_pkg::COORD_BITS_DEF)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .vertex (vertex_bus),
        .result (result_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    vertex_word_t pending_words [$];
    hull_result_t expected_hulls [$];

    int   src_idle_pct;
    int   snk_idle_pct;
    logic sink_hold;
    int   words_queued;
    int   mismatches;

    // running hull of the polyhedron being received
    coord_t held_pts [0:MAX_PTS-1][0:2];
    int     held_count;
    coord_t box_lo [0:2];
    coord_t box_hi [0:2];
    bit     dropped_seen;

    task automatic clear_hull();
        held_count   = 0;
        dropped_seen = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            box_lo[k] = psd_pkg::BOX_MIN_INIT;
            box_hi[k] = psd_pkg::BOX_MAX_INIT;
        end
    endtask

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic longint unsigned span_sq(input int a, input int b);
        longint          d;
        longint unsigned s;
        s = 0;
        for (int k = 0; k < 3; k++)
        begin
            d = longint'(held_pts[a][k]) - longint'(held_pts[b][k]);
            s += longint'(d * d);
        end
        return s;
    endfunction

    task automatic absorb_vertex(input vertex_word_t w);
        coord_t          c [0:2];
        bit              dup;
        longint unsigned widest;
        longint unsigned s;
        longint unsigned root;
        hull_result_t    h;
        c[0] = w.x;
        c[1] = w.y;
        c[2] = w.z;
        for (int k = 0; k < 3; k++)
        begin
            if (c[k] < box_lo[k])
                box_lo[k] = c[k];
            if (c[k] > box_hi[k])
                box_hi[k] = c[k];
        end
        dup = 1'b0;
        for (int i = 0; i < held_count; i++)
            if (held_pts[i][0] == c[0] && held_pts[i][1] == c[1] && held_pts[i][2] == c[2])
                dup = 1'b1;
        if (!dup)
        begin
            if (held_count < MAX_PTS)
            begin
                for (int k = 0; k < 3; k++)
                    held_pts[held_count][k] = c[k];
                held_count++;
            end
            else
                dropped_seen = 1'b1;
        end
        if (!w.last_vertex)
            return;
        widest = 0;
        for (int i = 0; i < held_count; i++)
            for (int j = i + 1; j < held_count; j++)
            begin
                s = span_sq(i, j);
                if (s > widest)
                    widest = s;
            end
        root = floor_sqrt(widest);
        if (root > {psd_pkg::DIAM_W{1'b1}})
            root = {psd_pkg::DIAM_W{1'b1}};
        h.min_x     = box_lo[0];
        h.max_x     = box_hi[0];
        h.min_y     = box_lo[1];
        h.max_y     = box_hi[1];
        h.min_z     = box_lo[2];
        h.max_z     = box_hi[2];
        h.diameter  = root[psd_pkg::DIAM_W-1:0];
        h.truncated = dropped_seen;
        expected_hulls.push_back(h);
        clear_hull();
    endtask

    task automatic report_mismatch(input string what, input longint want, input longint got);
        if (mismatches < 10)
            $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    // vertex driver
    always @(posedge clk or negedge rst_n)
    begin : drive
        vertex_word_t next_word;
        vertex_word_t taken;
        if (!rst_n)
        begin
            vertex_bus.valid       <= 1'b0;
            vertex_bus.coord_x     <= '0;
            vertex_bus.coord_y     <= '0;
            vertex_bus.coord_z     <= '0;
            vertex_bus.last_vertex <= 1'b0;
        end
        else
        begin
            if (vertex_bus.valid && vertex_bus.ready)
            begin
                taken.x           = vertex_bus.coord_x;
                taken.y           = vertex_bus.coord_y;
                taken.z           = vertex_bus.coord_z;
                taken.last_vertex = vertex_bus.last_vertex;
                absorb_vertex(taken);
            end
            if (!vertex_bus.valid || vertex_bus.ready)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    next_word = pending_words.pop_front();
                    vertex_bus.valid       <= 1'b1;
                    vertex_bus.coord_x     <= next_word.x;
                    vertex_bus.coord_y     <= next_word.y;
                    vertex_bus.coord_z     <= next_word.z;
                    vertex_bus.last_vertex <= next_word.last_vertex;
                end
                else
                    vertex_bus.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : watch
        hull_result_t got;
        hull_result_t want;
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                got.min_x     = result_bus.box_min_x;
                got.max_x     = result_bus.box_max_x;
                got.min_y     = result_bus.box_min_y;
                got.max_y     = result_bus.box_max_y;
                got.min_z     = result_bus.box_min_z;
                got.max_z     = result_bus.box_max_z;
                got.diameter  = result_bus.diameter;
                got.truncated = result_bus.truncated;
                if (expected_hulls.size() == 0)
                    report_mismatch("unexpected result word", 0, got.diameter);
                else
                begin
                    want = expected_hulls.pop_front();
                    if (got.min_x !== want.min_x)
                        report_mismatch("box_min_x", want.min_x, got.min_x);
                    if (got.max_x !== want.max_x)
                        report_mismatch("box_max_x", want.max_x, got.max_x);
                    if (got.min_y !== want.min_y)
                        report_mismatch("box_min_y", want.min_y, got.min_y);
                    if (got.max_y !== want.max_y)
                        report_mismatch("box_max_y", want.max_y, got.max_y);
                    if (got.min_z !== want.min_z)
                        report_mismatch("box_min_z", want.min_z, got.min_z);
                    if (got.max_z !== want.max_z)
                        report_mismatch("box_max_z", want.max_z, got.max_z);
                    if (got.diameter !== want.diameter)
                        report_mismatch("diameter", want.diameter, got.diameter);
                    if (got.truncated !== want.truncated)
                        report_mismatch("truncated", want.truncated, got.truncated);
                end
            end
            result_bus.ready <= !sink_hold && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic push_vertex(input coord_t x, input coord_t y, input coord_t z, input bit last);
        vertex_word_t w;
        w.x           = x;
        w.y           = y;
        w.z           = z;
        w.last_vertex = last;
        pending_words.push_back(w);
        words_queued++;
    endtask

    function automatic coord_t pick_coord(input int style);
        case (style)
            0:       return coord_t'($urandom);
            1:       return coord_t'(int'($urandom_range(511)) - 256);
            2:
            begin
                case ($urandom_range(4))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return 16'sh0000;
                    3:       return 16'shFFFF;
                    default: return coord_t'($urandom);
                endcase
            end
            default: return coord_t'(int'($urandom_range(2047)) + 28000);
        endcase
    endfunction

    task automatic push_random_shape(input int n);
        vertex_word_t shape [$];
        vertex_word_t w;
        int           style;
        style = $urandom_range(3);
        for (int i = 0; i < n; i++)
        begin
            // repeat an earlier vertex now and then
            if (i > 0 && $urandom_range(7) == 0)
                w = shape[$urandom_range(shape.size() - 1)];
            else
            begin
                w.x = pick_coord(style);
                w.y = pick_coord(style);
                w.z = pick_coord(style);
            end
            shape.push_back(w);
            push_vertex(w.x, w.y, w.z, i == n - 1);
        end
    endtask

    function automatic int shape_size();
        if ($urandom_range(19) == 0)
            return $urandom_range(13, 40);
        return $urandom_range(1, 10);
    endfunction

    // distinct vertices, then repeats of the first one; z keeps them apart
    task automatic push_crowd(input int distinct, input int repeats);
        vertex_word_t first_w;
        first_w = '0;
        for (int i = 0; i < distinct; i++)
        begin
            push_vertex(coord_t'($urandom), coord_t'($urandom), coord_t'(i * 100 - 16000),
                        repeats == 0 && i == distinct - 1);
            if (i == 0)
                first_w = pending_words[pending_words.size() - 1];
        end
        for (int r = 0; r < repeats; r++)
            push_vertex(first_w.x, first_w.y, first_w.z, r == repeats - 1);
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || vertex_bus.valid || expected_hulls.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        vertex_word_t first;
        rst_n                  = 1'b0;
        vertex_bus.valid       = 1'b0;
        vertex_bus.coord_x     = '0;
        vertex_bus.coord_y     = '0;
        vertex_bus.coord_z     = '0;
        vertex_bus.last_vertex = 1'b0;
        result_bus.ready       = 1'b0;
        sink_hold              = 1'b0;
        src_idle_pct           = 15;
        snk_idle_pct           = 77;
        words_queued           = 0;
        mismatches             = 0;
        clear_hull();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single vertex, zero diameter
        push_vertex(coord_t'(0), coord_t'(0), coord_t'(0), 1'b1);
        push_vertex(coord_t'(-32768), coord_t'(32767), coord_t'(-1), 1'b1);
        // opposite corners of the full range
        push_vertex(coord_t'(-32768), coord_t'(-32768), coord_t'(-32768), 1'b0);
        push_vertex(coord_t'(32767), coord_t'(32767), coord_t'(32767), 1'b1);
        // only repeats of one vertex
        push_vertex(coord_t'(100), coord_t'(-200), coord_t'(300), 1'b0);
        push_vertex(coord_t'(100), coord_t'(-200), coord_t'(300), 1'b0);
        push_vertex(coord_t'(100), coord_t'(-200), coord_t'(300), 1'b1);
        push_vertex(coord_t'(32767), coord_t'(-32768), coord_t'(0), 1'b0);
        push_vertex(coord_t'(-32768), coord_t'(32767), coord_t'(0), 1'b0);
        push_vertex(coord_t'(32767), coord_t'(-32768), coord_t'(0), 1'b0);
        push_vertex(coord_t'(0), coord_t'(0), coord_t'(32767), 1'b0);
        push_vertex(coord_t'(0), coord_t'(0), coord_t'(-32768), 1'b1);
        push_vertex(coord_t'(5), coord_t'(5), coord_t'(5), 1'b0);
        push_vertex(coord_t'(5), coord_t'(5), coord_t'(5), 1'b0);
        push_vertex(coord_t'(-5), coord_t'(-5), coord_t'(-5), 1'b1);
        push_vertex(coord_t'(-1), coord_t'(-1), coord_t'(-1), 1'b0);
        push_vertex(coord_t'(1), coord_t'(1), coord_t'(1), 1'b1);

        while (words_queued < 650)
            push_random_shape(shape_size());
        drain();

        src_idle_pct = 77;
        snk_idle_pct = 15;
        while (words_queued < 1200)
            push_random_shape(shape_size());
        drain();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        fork
            begin
                sink_hold <= 1'b1;
                repeat (1500) @(posedge clk);
                sink_hold <= 1'b0;
            end
        join_none
        repeat (30)
            push_random_shape($urandom_range(1, 4));
        drain();

        // store exactly full, then repeats: not truncated
        push_crowd(MAX_PTS, 2);
        drain();
        // store overflows
        push_crowd(MAX_PTS + 6, 0);
        first.x = coord_t'($urandom);
        push_vertex(first.x, first.x, 16'sh0000, 1'b1);
        drain();

        while (words_queued < 1900)
            push_random_shape(shape_size());
        drain();

        repeat (300) @(posedge clk);
        if (mismatches == 0 && expected_hulls.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
